// ===== src/a2d_pkg.sv =====
// shared types and constants for the 2d affine compose and transform block
// no dependencies; imported by the controller, the datapath and the top level
package a2d_pkg;

  localparam int OPCODE_W           = 2;
  localparam int TRIG_W             = 16;
  localparam int DIST_W             = 48;
  localparam int DEF_COORD_WIDTH    = 24;
  localparam int DEF_COEF_FRAC_BITS = 14;

  typedef enum logic [OPCODE_W-1:0] {
    OP_IDENT = 2'd0,
    OP_TRANS = 2'd1,
    OP_ROT   = 2'd2,
    OP_POINT = 2'd3
  } op_t;

  // operand selection of the shared multiplier unit
  typedef enum logic [1:0] {
    SEL_COL0 = 2'd0,
    SEL_COL1 = 2'd1,
    SEL_OFS  = 2'd2,
    SEL_PT   = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     ident;
    logic     trans;
    logic     mul;
    mul_sel_t sel;
    logic     wb_rot;
    logic     wb_pt;
    logic     sqr;
    logic     fin;
  } dp_cmd_t;

endpackage

// ===== src/a2d_ctrl.sv =====
// sequencing state machine: input and output handshakes, datapath commands
// depends on a2d_pkg
module a2d_ctrl
  import a2d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  output logic                out_valid,
  input  logic                out_ready,
  output dp_cmd_t             cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_SQR,
    S_FIN
  } state_t;

  state_t   state_r;
  op_t      op_r;
  mul_sel_t sel_r;
  logic     out_valid_r;
  logic     in_fire;
  logic     fin_go;
  op_t      in_op;

  assign in_op     = op_t'(in_opcode);
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // command decode
  always_comb begin
    cmd     = '0;
    cmd.sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_IDENT: cmd.ident = 1'b1;
            OP_TRANS: cmd.trans = 1'b1;
            OP_ROT:   cmd.load  = 1'b1;
            OP_POINT: cmd.load  = 1'b1;
            default:  cmd.load  = 1'b0;
          endcase
        end
      end
      S_MUL: cmd.mul = 1'b1;
      S_ACC: begin
        if (op_r == OP_POINT) begin
          cmd.wb_pt = 1'b1;
        end else begin
          cmd.wb_rot = 1'b1;
        end
      end
      S_SQR: cmd.sqr = 1'b1;
      S_FIN: cmd.fin = fin_go;
      default: cmd.sel = sel_r;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_IDENT;
      sel_r       <= SEL_COL0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r <= in_op;
            if (in_op == OP_ROT) begin
              sel_r   <= SEL_COL0;
              state_r <= S_MUL;
            end else if (in_op == OP_POINT) begin
              sel_r   <= SEL_PT;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          if (op_r == OP_POINT) begin
            state_r <= S_SQR;
          end else if (sel_r == SEL_OFS) begin
            state_r <= S_IDLE;
          end else begin
            // next column of the rotation
            sel_r   <= (sel_r == SEL_COL0) ? SEL_COL1 : SEL_OFS;
            state_r <= S_MUL;
          end
        end
        S_SQR: state_r <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/a2d_dp.sv =====
// datapath: transform state, four-multiplier unit, rounding, saturation,
// distance squares and running minimum; depends on a2d_pkg
module a2d_dp
  import a2d_pkg::*;
#(
  parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic signed [TRIG_W-1:0]      in_cos_term,
  input  logic signed [TRIG_W-1:0]      in_sin_term,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic        [DIST_W-1:0]      out_dist_sq,
  output logic        [DIST_W-1:0]      out_min_dist_sq
);

  localparam int CW    = COORD_WIDTH;
  localparam int F     = COEF_FRAC_BITS;
  localparam int LIN_W = F + 2;
  localparam int AW    = (LIN_W > TRIG_W) ? LIN_W : TRIG_W;
  localparam int BW    = (CW > LIN_W) ? CW : LIN_W;
  localparam int PW    = AW + BW;
  localparam int SUM_W = PW + 2;
  localparam int RW    = SUM_W - F;
  localparam int TW    = RW + 1;
  localparam int SQ_W  = 2 * CW;
  localparam int DS_W  = SQ_W + 1;
  localparam int EXT_W = (DS_W > DIST_W) ? DS_W : DIST_W + 1;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (F - 1));
  localparam logic signed [RW-1:0] LIN_HI = {{(RW-LIN_W+1){1'b0}}, {(LIN_W-1){1'b1}}};
  localparam logic signed [RW-1:0] LIN_LO = {{(RW-LIN_W+1){1'b1}}, {(LIN_W-1){1'b0}}};
  localparam logic signed [RW-1:0] CRD_HI = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [RW-1:0] CRD_LO = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [TW-1:0] PT_HI  = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [TW-1:0] PT_LO  = {{(TW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [CW:0]   ADD_HI = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [CW:0]   ADD_LO = {2'b11, {(CW-1){1'b0}}};
  localparam logic [EXT_W-1:0]     DMAX   = {{(EXT_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};
  localparam logic signed [LIN_W-1:0] ONE = {2'b01, {F{1'b0}}};

  function automatic logic signed [LIN_W-1:0] sat_lin(input logic signed [RW-1:0] v);
    if (v > LIN_HI) return LIN_HI[LIN_W-1:0];
    if (v < LIN_LO) return LIN_LO[LIN_W-1:0];
    return v[LIN_W-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_crd(input logic signed [RW-1:0] v);
    if (v > CRD_HI) return CRD_HI[CW-1:0];
    if (v < CRD_LO) return CRD_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_pt(input logic signed [TW-1:0] v);
    if (v > PT_HI) return PT_HI[CW-1:0];
    if (v < PT_LO) return PT_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW:0] v);
    if (v > ADD_HI) return ADD_HI[CW-1:0];
    if (v < ADD_LO) return ADD_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  // transform state, row-major L00 L01 L10 L11
  logic signed [LIN_W-1:0]  lin_r [4];
  logic signed [CW-1:0]     ox_r;
  logic signed [CW-1:0]     oy_r;
  logic        [DIST_W-1:0] min_r;

  // captured item
  logic signed [CW-1:0]     x_r;
  logic signed [CW-1:0]     y_r;
  logic signed [TRIG_W-1:0] c_r;
  logic signed [TRIG_W-1:0] s_r;

  // multiplier unit
  logic signed [AW-1:0]     ma [4];
  logic signed [BW-1:0]     mb [4];
  logic signed [PW-1:0]     prod [4];
  logic signed [PW-1:0]     p_r [4];
  logic signed [BW-1:0]     col_top;
  logic signed [BW-1:0]     col_bot;

  // accumulate and round
  logic signed [SUM_W-1:0]  sum0;
  logic signed [SUM_W-1:0]  sum1;
  logic signed [RW-1:0]     rnd0;
  logic signed [RW-1:0]     rnd1;
  logic signed [TW-1:0]     pt0;
  logic signed [TW-1:0]     pt1;

  // distance
  logic signed [CW-1:0]     tx_r;
  logic signed [CW-1:0]     ty_r;
  logic        [CW-1:0]     ax;
  logic        [CW-1:0]     ay;
  logic        [SQ_W-1:0]   sqx_r;
  logic        [SQ_W-1:0]   sqy_r;
  logic        [EXT_W-1:0]  dsum;
  logic        [DIST_W-1:0] dist_val;
  logic        [DIST_W-1:0] min_nxt;

  // operand selection
  always_comb begin
    col_top = BW'(lin_r[0]);
    col_bot = BW'(lin_r[2]);
    unique case (cmd.sel)
      SEL_COL0: begin
        col_top = BW'(lin_r[0]);
        col_bot = BW'(lin_r[2]);
      end
      SEL_COL1: begin
        col_top = BW'(lin_r[1]);
        col_bot = BW'(lin_r[3]);
      end
      SEL_OFS: begin
        col_top = BW'(ox_r);
        col_bot = BW'(oy_r);
      end
      SEL_PT: begin
        col_top = BW'(x_r);
        col_bot = BW'(y_r);
      end
      default: col_top = BW'(lin_r[0]);
    endcase
    if (cmd.sel == SEL_PT) begin
      ma[0] = AW'(lin_r[0]); mb[0] = col_top;
      ma[1] = AW'(lin_r[1]); mb[1] = col_bot;
      ma[2] = AW'(lin_r[2]); mb[2] = col_top;
      ma[3] = AW'(lin_r[3]); mb[3] = col_bot;
    end else begin
      ma[0] = AW'(c_r); mb[0] = col_top;
      ma[1] = AW'(s_r); mb[1] = col_bot;
      ma[2] = AW'(s_r); mb[2] = col_top;
      ma[3] = AW'(c_r); mb[3] = col_bot;
    end
    for (int i = 0; i < 4; i++) begin
      prod[i] = PW'(ma[i]) * PW'(mb[i]);
    end
  end

  // product registers and captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_coord_x;
      y_r <= in_coord_y;
      c_r <= in_cos_term;
      s_r <= in_sin_term;
    end
    if (cmd.mul) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= prod[i];
      end
    end
  end

  // pair sums, round to nearest with ties up
  assign sum0 = SUM_W'(p_r[0]) + ((cmd.sel == SEL_PT) ? SUM_W'(p_r[1]) : -SUM_W'(p_r[1]))
              + HALF;
  assign sum1 = SUM_W'(p_r[2]) + SUM_W'(p_r[3]) + HALF;
  assign rnd0 = RW'(sum0 >>> F);
  assign rnd1 = RW'(sum1 >>> F);
  assign pt0  = TW'(rnd0) + TW'(ox_r);
  assign pt1  = TW'(rnd1) + TW'(oy_r);

  // transform state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r[0] <= ONE;
      lin_r[1] <= '0;
      lin_r[2] <= '0;
      lin_r[3] <= ONE;
      ox_r     <= '0;
      oy_r     <= '0;
      min_r    <= '1;
    end else begin
      if (cmd.ident) begin
        lin_r[0] <= ONE;
        lin_r[1] <= '0;
        lin_r[2] <= '0;
        lin_r[3] <= ONE;
        ox_r     <= '0;
        oy_r     <= '0;
      end
      if (cmd.trans) begin
        ox_r <= sat_add((CW+1)'(ox_r) + (CW+1)'(in_coord_x));
        oy_r <= sat_add((CW+1)'(oy_r) + (CW+1)'(in_coord_y));
      end
      if (cmd.wb_rot) begin
        unique case (cmd.sel)
          SEL_COL0: begin
            lin_r[0] <= sat_lin(rnd0);
            lin_r[2] <= sat_lin(rnd1);
          end
          SEL_COL1: begin
            lin_r[1] <= sat_lin(rnd0);
            lin_r[3] <= sat_lin(rnd1);
          end
          SEL_OFS: begin
            ox_r <= sat_crd(rnd0);
            oy_r <= sat_crd(rnd1);
          end
          SEL_PT: begin
            ox_r <= ox_r;
          end
          default: begin
            ox_r <= ox_r;
          end
        endcase
      end
      if (cmd.fin) begin
        min_r <= min_nxt;
      end
    end
  end

  // magnitudes and squares
  assign ax = tx_r[CW-1] ? CW'(-tx_r) : CW'(tx_r);
  assign ay = ty_r[CW-1] ? CW'(-ty_r) : CW'(ty_r);

  always_ff @(posedge clk) begin
    if (cmd.wb_pt) begin
      tx_r <= sat_pt(pt0);
      ty_r <= sat_pt(pt1);
    end
    if (cmd.sqr) begin
      sqx_r <= SQ_W'(ax) * SQ_W'(ax);
      sqy_r <= SQ_W'(ay) * SQ_W'(ay);
    end
  end

  // distance sum with saturation and running minimum
  assign dsum     = EXT_W'(sqx_r) + EXT_W'(sqy_r);
  assign dist_val = (dsum > DMAX) ? DMAX[DIST_W-1:0] : dsum[DIST_W-1:0];
  assign min_nxt  = (dist_val < min_r) ? dist_val : min_r;

  // output beat register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_x           <= tx_r;
      out_y           <= ty_r;
      out_dist_sq     <= dist_val;
      out_min_dist_sq <= min_nxt;
    end
  end

endmodule

// ===== src/affine_2d_compose_and_transform_top.sv =====
// Composed 2d homogeneous affine transform. Each input beat carries an opcode: identity
// resets the transform, translate adds the offset, rotate prepends [c -s; s c] to the
// linear part and the offset, and point pushes (x, y) through the transform and returns
// one output beat with the saturated point, its squared distance to the origin and the
// running minimum of that distance since reset. Identity and translate apply on acceptance.
// Rotation: one four-multiplier unit walks the three matrix columns, with a multiply
// step and a round/saturate write-back step for each. A point goes through capture,
// multiply, sum and offset, square and final sum before its result is in the
// output register; the next beat is accepted while that result waits to be taken, and
// the block only stalls in the last step if the previous result is still unread.
// Depends on a2d_pkg, a2d_ctrl and a2d_dp.
module affine_2d_compose_and_transform_top
  import a2d_pkg::*;
#(
  parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OPCODE_W-1:0]           in_opcode,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic signed [TRIG_W-1:0]      in_cos_term,
  input  logic signed [TRIG_W-1:0]      in_sin_term,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic        [DIST_W-1:0]      out_dist_sq,
  output logic        [DIST_W-1:0]      out_min_dist_sq
);

  dp_cmd_t cmd;

  a2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  a2d_dp #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_cos_term     (in_cos_term),
    .in_sin_term     (in_sin_term),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_dist_sq     (out_dist_sq),
    .out_min_dist_sq (out_min_dist_sq)
  );

`ifndef SYNTHESIS
  // a result beat only appears after the final step loaded the output register
  a_rose_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.fin))
    else $error("out_valid rose without a final step");

  // an accepted point keeps the block busy for the next cycle
  a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == OP_POINT)) |=> !in_ready)
    else $error("point accepted but block not busy");

  // running minimum never exceeds the distance of the same beat
  a_min_le_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_dist_sq <= out_dist_sq))
    else $error("running minimum above distance");

  // the final step never overlaps a new acceptance
  a_fin_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !in_ready)
    else $error("final step while idle");
`endif

endmodule

// ===== tb/sv/tb_affine_2d_compose_and_transform_top.sv =====
// self-checking testbench for the 2d affine compose and transform block
// directed table, then random beats, checked by a fixed-point predictor or table
// depends on a2d_pkg and affine_2d_compose_and_transform_top
`timescale 1ns / 1ps

module tb_affine_2d_compose_and_transform_top;
  import a2d_pkg::*;

  localparam int CW          = DEF_COORD_WIDTH;
  localparam int CFRAC       = DEF_COEF_FRAC_BITS;
  localparam int LIN_W       = CFRAC + 2;
  localparam int RANDOM_BEATS = 850;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 700;
  localparam int TAIL_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint DIST_MAX = (64'sd1 <<< DIST_W) - 1;

  localparam logic signed [CW-1:0]     XMAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]     XMIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [TRIG_W-1:0] Q_ONE = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] Q_NEG = -16'sd16384;
  localparam logic signed [TRIG_W-1:0] Q_HALF = 16'sd8192;
  localparam logic signed [TRIG_W-1:0] T_MAX = 16'sh7fff;
  localparam logic signed [TRIG_W-1:0] T_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [DIST_W-1:0]    d;
    logic [DIST_W-1:0]    m;
  } point_res_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]      op;
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     y;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    logic                     typed;
    point_res_t               want;
  } plan_row_t;

  localparam point_res_t NO_PT = '0;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OPCODE_W-1:0]      in_opcode = '0;
  logic signed [CW-1:0]     in_coord_x = '0;
  logic signed [CW-1:0]     in_coord_y = '0;
  logic signed [TRIG_W-1:0] in_cos_term = '0;
  logic signed [TRIG_W-1:0] in_sin_term = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CW-1:0]     out_x;
  logic signed [CW-1:0]     out_y;
  logic [DIST_W-1:0]        out_dist_sq;
  logic [DIST_W-1:0]        out_min_dist_sq;

  // predicted transform state
  longint lin_q [4];
  longint ofs_q [2];
  longint min_dist_q;

  point_res_t pending_points [$];
  plan_row_t  plan [$];
  int         bad_beats = 0;
  int         beats_sent = 0;
  int         cycle_count = 0;
  bit         send_calm = 1'b0;

  affine_2d_compose_and_transform_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_cos_term     (in_cos_term),
    .in_sin_term     (in_sin_term),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_dist_sq     (out_dist_sq),
    .out_min_dist_sq (out_min_dist_sq)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic longint clamp_bits(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round to nearest, ties up: add half an lsb then floor
  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (CFRAC - 1))) >>> CFRAC;
  endfunction

  // append one row to the directed table
  task automatic add_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endtask

  task automatic reset_transform_model();
    lin_q[0] = 64'sd1 <<< CFRAC;
    lin_q[1] = 0;
    lin_q[2] = 0;
    lin_q[3] = 64'sd1 <<< CFRAC;
    ofs_q[0] = 0;
    ofs_q[1] = 0;
  endtask

  task automatic predict_affine_step(input op_t op, input logic signed [CW-1:0] x, y,
                                     input logic signed [TRIG_W-1:0] c, s,
                                     output bit has_pt, output point_res_t pt);
    longint xl, yl, cl, sl;
    longint l00, l01, l10, l11, ox, oy;
    longint tx, ty, ax, ay, dd;
    xl = longint'(x);
    yl = longint'(y);
    cl = longint'(c);
    sl = longint'(s);
    has_pt = 1'b0;
    pt = NO_PT;
    case (op)
      OP_IDENT: begin
        reset_transform_model();
      end
      OP_TRANS: begin
        ofs_q[0] = clamp_bits(ofs_q[0] + xl, CW);
        ofs_q[1] = clamp_bits(ofs_q[1] + yl, CW);
      end
      OP_ROT: begin
        // new = [c -s; s c] * old, linear part and offset alike
        l00 = lin_q[0]; l01 = lin_q[1]; l10 = lin_q[2]; l11 = lin_q[3];
        ox = ofs_q[0]; oy = ofs_q[1];
        lin_q[0] = clamp_bits(round_q(cl * l00 - sl * l10), LIN_W);
        lin_q[1] = clamp_bits(round_q(cl * l01 - sl * l11), LIN_W);
        lin_q[2] = clamp_bits(round_q(sl * l00 + cl * l10), LIN_W);
        lin_q[3] = clamp_bits(round_q(sl * l01 + cl * l11), LIN_W);
        ofs_q[0] = clamp_bits(round_q(cl * ox - sl * oy), CW);
        ofs_q[1] = clamp_bits(round_q(sl * ox + cl * oy), CW);
      end
      default: begin
        tx = clamp_bits(round_q(lin_q[0] * xl + lin_q[1] * yl) + ofs_q[0], CW);
        ty = clamp_bits(round_q(lin_q[2] * xl + lin_q[3] * yl) + ofs_q[1], CW);
        ax = (tx < 0) ? -tx : tx;
        ay = (ty < 0) ? -ty : ty;
        dd = ax * ax + ay * ay;
        if (dd > DIST_MAX) dd = DIST_MAX;
        if (dd < min_dist_q) min_dist_q = dd;
        has_pt = 1'b1;
        pt.x = tx[CW-1:0];
        pt.y = ty[CW-1:0];
        pt.d = dd[DIST_W-1:0];
        pt.m = min_dist_q[DIST_W-1:0];
      end
    endcase
  endtask

  // offer one input beat after a random gap, then update the prediction
  task automatic offer_beat(input op_t op, input logic signed [CW-1:0] x, y,
                            input logic signed [TRIG_W-1:0] c, s,
                            input logic typed, input point_res_t want);
    int         gap;
    bit         has_pt;
    point_res_t pt;
    if (beats_sent % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_coord_x  <= x;
    in_coord_y  <= y;
    in_cos_term <= c;
    in_sin_term <= s;
    do @(posedge clk); while (!in_ready);
    predict_affine_step(op, x, y, c, s, has_pt, pt);
    if (has_pt) pending_points.insert(pending_points.size(), typed ? want : pt);
    beats_sent++;
  endtask

  // result sink: random stalls plus one long hold-off
  initial begin : result_sink
    int gap;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 16);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // compare each accepted result beat with the oldest queued expectation
  always @(posedge clk) begin : result_check
    point_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        if (bad_beats < 10)
          $display("unexpected result beat: x=%0d y=%0d d=%0d m=%0d",
                   out_x, out_y, out_dist_sq, out_min_dist_sq);
        bad_beats++;
      end else begin
        want = pending_points.pop_front();
        if (out_x !== want.x || out_y !== want.y ||
            out_dist_sq !== want.d || out_min_dist_sq !== want.m) begin
          if (bad_beats < 10)
            $display("mismatch: exp x=%0d y=%0d d=%0d m=%0d got x=%0d y=%0d d=%0d m=%0d",
                     want.x, want.y, want.d, want.m,
                     out_x, out_y, out_dist_sq, out_min_dist_sq);
          bad_beats++;
        end
      end
    end
  end

  initial begin : stimulus
    op_t       op;
    logic signed [CW-1:0]     rx, ry;
    logic signed [TRIG_W-1:0] rc, rs;
    int        pick;
    int        ci, si;
    real       ang;

    reset_transform_model();
    min_dist_q = DIST_MAX;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed rows hold the results expected from the rows before them
    add_row('{OP_POINT, 24'sd256, 24'sd0, 16'sd0, 16'sd0, 1'b1,
              '{24'sd256, 24'sd0, 48'd65536, 48'd65536}});
    add_row('{OP_POINT, XMAX, XMAX, T_MAX, T_MIN, 1'b1,
              '{XMAX, XMAX, 48'd140737454800898, 48'd65536}});
    add_row('{OP_POINT, XMIN, XMIN, T_MIN, T_MAX, 1'b1,
              '{XMIN, XMIN, 48'd140737488355328, 48'd65536}});
    add_row('{OP_POINT, XMIN, XMAX, 16'sd0, 16'sd0, 1'b1,
              '{XMIN, XMAX, 48'd140737471578113, 48'd65536}});
    // identity with every unused field set
    add_row('{OP_IDENT, -24'sd1, -24'sd1, -16'sd1, -16'sd1, 1'b0, NO_PT});
    // offsets pushed into saturation
    add_row('{OP_TRANS, XMAX, XMIN, T_MAX, T_MIN, 1'b0, NO_PT});
    add_row('{OP_TRANS, XMAX, XMIN, T_MIN, T_MAX, 1'b0, NO_PT});
    add_row('{OP_POINT, 24'sd256, -24'sd256, 16'sd0, 16'sd0, 1'b1,
              '{XMAX, XMIN, 48'd140737471578113, 48'd65536}});
    add_row('{OP_IDENT, XMAX, XMIN, T_MAX, T_MIN, 1'b0, NO_PT});
    add_row('{OP_TRANS, -24'sd25600, 24'sd12800, T_MAX, T_MIN, 1'b0, NO_PT});
    add_row('{OP_POINT, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b1,
              '{-24'sd25600, 24'sd12800, 48'd819200000, 48'd65536}});
    add_row('{OP_IDENT, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, NO_PT});
    // quarter turn, then scaling rotations that drive the linear part to its limits
    add_row('{OP_ROT, XMAX, XMIN, 16'sd0, Q_ONE, 1'b0, NO_PT});
    add_row('{OP_POINT, 24'sd256, 24'sd512, 16'sd0, 16'sd0, 1'b0, NO_PT});
    add_row('{OP_ROT, 24'sd0, 24'sd0, Q_ONE, Q_ONE, 1'b0, NO_PT});
    add_row('{OP_ROT, 24'sd0, 24'sd0, Q_ONE, Q_ONE, 1'b0, NO_PT});
    add_row('{OP_ROT, 24'sd0, 24'sd0, Q_NEG, Q_NEG, 1'b0, NO_PT});
    add_row('{OP_ROT, 24'sd0, 24'sd0, T_MAX, T_MIN, 1'b0, NO_PT});
    add_row('{OP_POINT, XMIN, XMAX, 16'sd0, 16'sd0, 1'b0, NO_PT});
    // rounding ties on the offset and on the point product
    add_row('{OP_IDENT, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, NO_PT});
    add_row('{OP_TRANS, 24'sd1, -24'sd1, 16'sd0, 16'sd0, 1'b0, NO_PT});
    add_row('{OP_ROT, 24'sd0, 24'sd0, Q_HALF, 16'sd0, 1'b0, NO_PT});
    add_row('{OP_TRANS, 24'sd25600, 24'sd25600, 16'sd0, 16'sd0, 1'b0, NO_PT});
    add_row('{OP_POINT, 24'sd1, -24'sd1, 16'sd0, 16'sd0, 1'b0, NO_PT});

    foreach (plan[i])
      offer_beat(op_t'(plan[i].op), plan[i].x, plan[i].y, plan[i].c, plan[i].s,
                 plan[i].typed, plan[i].want);

    // random beats: mostly points, with translations, rotations and resets between
    repeat (RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) op = OP_IDENT;
      else if (pick < 20) op = OP_TRANS;
      else if (pick < 34) op = OP_ROT;
      else op = OP_POINT;

      rx = CW'($urandom);
      ry = CW'($urandom);
      rc = TRIG_W'($urandom);
      rs = TRIG_W'($urandom);
      pick = $urandom_range(0, 9);
      if (op == OP_POINT) begin
        if (pick < 7) begin
          rx = CW'($urandom_range(0, 131072) - 65536);
          ry = CW'($urandom_range(0, 131072) - 65536);
        end else if (pick < 9) begin
          rx = CW'($urandom_range(0, 2097152) - 1048576);
          ry = CW'($urandom_range(0, 2097152) - 1048576);
        end
      end else if (op == OP_TRANS) begin
        if (pick < 8) begin
          rx = CW'($urandom_range(0, 32768) - 16384);
          ry = CW'($urandom_range(0, 32768) - 16384);
        end
      end else if (op == OP_ROT) begin
        // true rotations most of the time, else scale and shear
        if (pick < 6) begin
          ang = $urandom_range(0, 65535) * 6.283185307179586 / 65536.0;
          ci = $rtoi($floor(16384.0 * $cos(ang) + 0.5));
          si = $rtoi($floor(16384.0 * $sin(ang) + 0.5));
          rc = TRIG_W'(ci);
          rs = TRIG_W'(si);
        end else if (pick < 9) begin
          rc = TRIG_W'($urandom_range(0, 32768) - 16384);
          rs = TRIG_W'($urandom_range(0, 32768) - 16384);
        end
      end
      offer_beat(op, rx, ry, rc, rs, 1'b0, NO_PT);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then allow for the pipeline tail
    while (pending_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_beats == 0 && pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
